/* rtl/rne_pkg.sv */
// Shared types, codes and lookup functions for the Roman numeral encoder.
// No dependencies; used by rne_digits and roman_numeral_encoder.

package rne_pkg;

  // Largest value that has a numeral
  localparam logic signed [31:0] MAX_VALUE = 32'sd3999;

  // Decimal places: thousands, hundreds, tens, units
  localparam int NUM_PLACES = 4;

  localparam logic [1:0] PLACE_TH = 2'd0;
  localparam logic [1:0] PLACE_HU = 2'd1;
  localparam logic [1:0] PLACE_TE = 2'd2;
  localparam logic [1:0] PLACE_UN = 2'd3;

  // Status codes on the result port
  localparam logic [1:0] STATUS_LETTER = 2'd0;
  localparam logic [1:0] STATUS_ZERO   = 2'd1;
  localparam logic [1:0] STATUS_RANGE  = 2'd2;

  // ASCII codes of the numeral letters
  localparam logic [6:0] CHR_NONE = 7'h00;
  localparam logic [6:0] CHR_I    = 7'h49;
  localparam logic [6:0] CHR_V    = 7'h56;
  localparam logic [6:0] CHR_X    = 7'h58;
  localparam logic [6:0] CHR_L    = 7'h4C;
  localparam logic [6:0] CHR_C    = 7'h43;
  localparam logic [6:0] CHR_D    = 7'h44;
  localparam logic [6:0] CHR_M    = 7'h4D;

  // One decimal digit per place, thousands in element 0
  typedef logic [NUM_PLACES-1:0][3:0] digits_t;

  // Symbol role within a place: one, five or the next one
  typedef enum logic [1:0] {
    SEL_ONE,
    SEL_FIVE,
    SEL_TEN
  } sym_sel_t;

  // Weight subtracted while splitting off the digit of a place
  function automatic logic [11:0] place_weight(input logic [1:0] place);
    logic [11:0] w;
    unique case (place)
      PLACE_TH: w = 12'd1000;
      PLACE_HU: w = 12'd100;
      PLACE_TE: w = 12'd10;
      default:  w = 12'd1;
    endcase
    return w;
  endfunction

  // Number of letters that a digit writes out
  function automatic logic [2:0] pat_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  // Symbol role of letter pos within the pattern of digit d
  function automatic sym_sel_t pat_sel(input logic [3:0] d, input logic [1:0] pos);
    sym_sel_t s;
    s = SEL_ONE;
    if (d == 4'd4 && pos == 2'd1) begin
      s = SEL_FIVE;
    end else if (d == 4'd9 && pos == 2'd1) begin
      s = SEL_TEN;
    end else if (d >= 4'd5 && d <= 4'd8 && pos == 2'd0) begin
      s = SEL_FIVE;
    end
    return s;
  endfunction

  // ASCII letter for a place and symbol role
  function automatic logic [6:0] place_sym(input logic [1:0] place, input sym_sel_t sel);
    logic [6:0] c;
    c = CHR_NONE;
    unique case (place)
      PLACE_TH: c = CHR_M;
      PLACE_HU: c = (sel == SEL_ONE) ? CHR_C : ((sel == SEL_FIVE) ? CHR_D : CHR_M);
      PLACE_TE: c = (sel == SEL_ONE) ? CHR_X : ((sel == SEL_FIVE) ? CHR_L : CHR_C);
      default:  c = (sel == SEL_ONE) ? CHR_I : ((sel == SEL_FIVE) ? CHR_V : CHR_X);
    endcase
    return c;
  endfunction

endpackage

/* rtl/rne_digits.sv */
// Decimal digit splitter: one shared compare/subtract unit, repeated per place.
// Depends on rne_pkg.

module rne_digits (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [11:0]      num,
  output logic             done,
  output rne_pkg::digits_t digits
);

  logic        running;
  logic [11:0] rem;
  logic [1:0]  place;
  logic [3:0]  cnt;

  // Shared unit: compare and subtract the weight of the current place
  logic [11:0] weight;
  logic [12:0] diff;
  logic        fits;

  assign weight = rne_pkg::place_weight(place);
  assign diff   = {1'b0, rem} - {1'b0, weight};
  assign fits   = !diff[12];

  // Count subtractions per place, then move on; the tens place also stores the units digit
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        rem     <= num;
        place   <= rne_pkg::PLACE_TH;
        cnt     <= 4'd0;
      end else if (running) begin
        if (fits) begin
          rem <= diff[11:0];
          cnt <= cnt + 4'd1;
        end else begin
          digits[place] <= cnt;
          cnt           <= 4'd0;
          if (place == rne_pkg::PLACE_TE) begin
            digits[rne_pkg::PLACE_UN] <= rem[3:0];
            running <= 1'b0;
            done    <= 1'b1;
          end else begin
            place <= place + 2'd1;
          end
        end
      end
    end
  end

endmodule

/* rtl/roman_numeral_encoder.sv */
// Roman numeral encoder, top level: range check, digit split, letter sequencer.
// Out-of-range and zero values: one result the cycle after the transfer, busy stays low.
// Other values: busy while the digit splitter works, then one letter per cycle,
// with a gap for each zero place ahead of the last letter; busy drops with it.
// Worst case 3888: the longest numeral, 15 letters.
// Reset (rst, synchronous) returns to idle and clears the strobe; receiver cannot stall.

module roman_numeral_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [6:0]         letter,
  output logic [1:0]         status,
  output logic               last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_EMIT
  } state_t;

  state_t           state;
  logic [1:0]       place;
  logic [1:0]       pos;
  logic             split_done;
  rne_pkg::digits_t digits;

  logic accept;
  logic out_of_range;
  logic is_zero;
  logic split_go;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign out_of_range = value[31] || (value > rne_pkg::MAX_VALUE);
  assign is_zero      = (value == 32'sd0);
  assign split_go     = accept && !out_of_range && !is_zero;

  rne_digits u_digits (
    .clk    (clk),
    .rst    (rst),
    .go     (split_go),
    .num    (value[11:0]),
    .done   (split_done),
    .digits (digits)
  );

  // Current digit, its pattern and whether every later digit is zero
  logic [3:0]        dig;
  logic [2:0]        len;
  logic              pos_end;
  logic              rest_zero;
  rne_pkg::sym_sel_t sel;

  assign dig     = digits[place];
  assign len     = rne_pkg::pat_len(dig);
  assign pos_end = (({1'b0, pos} + 3'd1) == len);
  assign sel     = rne_pkg::pat_sel(dig, pos);

  always_comb begin
    rest_zero = 1'b1;
    for (int i = 0; i < rne_pkg::NUM_PLACES; i++) begin
      if (2'(i) > place && digits[i] != 4'd0) begin
        rest_zero = 1'b0;
      end
    end
  end

  // Sequencer and registered result port
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (out_of_range || is_zero) begin
              strobe <= 1'b1;
              letter <= rne_pkg::CHR_NONE;
              status <= out_of_range ? rne_pkg::STATUS_RANGE : rne_pkg::STATUS_ZERO;
              last   <= 1'b1;
            end else begin
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (split_done) begin
            state <= S_EMIT;
            place <= rne_pkg::PLACE_TH;
            pos   <= 2'd0;
          end
        end
        S_EMIT: begin
          if (len == 3'd0) begin
            // skip a zero place
            place <= place + 2'd1;
          end else begin
            strobe <= 1'b1;
            letter <= rne_pkg::place_sym(place, sel);
            status <= rne_pkg::STATUS_LETTER;
            last   <= pos_end && rest_zero;
            if (pos_end) begin
              pos   <= 2'd0;
              place <= place + 2'd1;
              if (rest_zero) begin
                state <= S_IDLE;
              end
            end else begin
              pos <= pos + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Special results always close their item
  a_special_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != rne_pkg::STATUS_LETTER |-> last)
    else $error("special result without last");

  // Letter results carry a real letter
  a_letter_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe && status == rne_pkg::STATUS_LETTER |-> letter != rne_pkg::CHR_NONE)
    else $error("letter result with no letter");

  // Out-of-range transfer answers in the next cycle
  a_range_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && out_of_range |=> strobe && status == rne_pkg::STATUS_RANGE)
    else $error("out-of-range transfer not answered");

  // Last letter of a numeral drops busy
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy after last result");

endmodule
